[rtl/nmbd_pkg.sv]
// nmbd_pkg: shared types and constants for the masked box downsampler.
// Used by the controller, the datapath and the top level.
package nmbd_pkg;

  localparam int MAX_CELLS_X_DEF = 64;
  localparam int MAX_CELLS_Y_DEF = 64;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 16;
  localparam int POS_W    = 10;
  localparam int BLK_W    = 6;
  localparam int REG_W    = 11;
  localparam int CFG_IDX_W = 3;
  localparam int QUO_W    = 48;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_Z = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take the input transfer
    logic div_start;  // load divider from the read-modify-write result
    logic div_step;   // one restoring division step
    logic out_load;   // move result to output register
  } nmbd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;       // accepted voxel closes a cell
    logic out_full;   // output register holds an untaken result
    logic div_last;   // divider at its final step
  } nmbd_sts_t;

endpackage

[rtl/nan_masked_box_downsampler_core.sv]
// nan_masked_box_downsampler_core: top level of the masked box downsampler.
// Instantiates nmbd_ctrl and nmbd_dp; depends on nmbd_pkg.
//
// Voxels of a 3D region enter on the s_axis channel in raster order, x
// fastest. Each transfer carries a Q16.16 sample and a NaN flag. Valid
// samples are summed and counted per output cell of block_x*block_y*block_z
// voxels; on the last voxel of a cell one transfer leaves on m_axis with the
// truncated mean and the cell indices, the empty flag on tuser.
// Timing: a voxel that closes no cell takes a store read, then a
// write-back. A voxel that closes a cell then runs the bit-serial divider
// (one quotient bit per cycle, over the 48-bit quotient), then loads the
// output register. The output register holds a result while the receiver
// stalls; the next voxel is taken meanwhile only after that load.
// Configuration: cfg_we/cfg_idx/cfg_data write one register per cycle;
// any write to a listed register restarts the frame at the origin. Write
// only while idle.
// Reset (rst, synchronous): all registers to 1, position to origin, no
// pending output. Sum and count stores are not cleared: the first voxel of
// each cell overwrites its entry.
module nan_masked_box_downsampler_core #(
  parameter int MAX_CELLS_X = nmbd_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y = nmbd_pkg::MAX_CELLS_Y_DEF,
  parameter int VALUE_BITS  = nmbd_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tuser,   // [0] is_nan
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] mean, [41:32] cell_x,
                                      // [51:42] cell_y, [61:52] cell_z,
                                      // [63:62] zero
  output logic        m_axis_tuser    // [0] empty_res
);

  nmbd_pkg::nmbd_cmd_t cmd;
  nmbd_pkg::nmbd_sts_t sts;
  logic signed [31:0] mean;
  logic empty_res;
  logic [9:0] cell_x, cell_y, cell_z;

  nmbd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  nmbd_dp #(
    .MAX_CELLS_X(MAX_CELLS_X), .MAX_CELLS_Y(MAX_CELLS_Y), .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .sample(s_axis_tdata), .is_nan(s_axis_tuser),
    .cmd(cmd), .sts(sts),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .mean(mean), .empty_res(empty_res),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z)
  );

  assign m_axis_tdata = {2'b00, cell_z, cell_y, cell_x, mean};
  assign m_axis_tuser = empty_res;

endmodule

[rtl/nmbd_ctrl.sv]
// nmbd_ctrl: controller state machine of the masked box downsampler.
// Depends on nmbd_pkg for command and status types.
module nmbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nmbd_pkg::nmbd_sts_t sts,
  output nmbd_pkg::nmbd_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RMW  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_RMW;
        end
      end
      ST_RMW: begin
        // store read data now registered; sum/count updated here
        if (sts.emit) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/nmbd_dp.sv]
// nmbd_dp: datapath: position counters, sum/count stores, serial divider,
// output register. Depends on nmbd_pkg.
module nmbd_dp #(
  parameter int MAX_CELLS_X = nmbd_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y = nmbd_pkg::MAX_CELLS_Y_DEF,
  parameter int VALUE_BITS  = nmbd_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nmbd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [nmbd_pkg::REG_W-1:0]        cfg_data,
  input  logic signed [nmbd_pkg::SAMPLE_W-1:0] sample,
  input  logic                              is_nan,
  input  nmbd_pkg::nmbd_cmd_t               cmd,
  output nmbd_pkg::nmbd_sts_t               sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [nmbd_pkg::SAMPLE_W-1:0] mean,
  output logic                              empty_res,
  output logic [nmbd_pkg::POS_W-1:0]        cell_x,
  output logic [nmbd_pkg::POS_W-1:0]        cell_y,
  output logic [nmbd_pkg::POS_W-1:0]        cell_z
);

  localparam int DEPTH  = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int AX_W   = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
  localparam int AY_W   = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VB     = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int SUM_W  = nmbd_pkg::SUM_W;
  localparam int CNT_W  = nmbd_pkg::CNT_W;
  localparam int POS_W  = nmbd_pkg::POS_W;
  localparam int BLK_W  = nmbd_pkg::BLK_W;
  localparam int REG_W  = nmbd_pkg::REG_W;
  localparam int QUO_W  = nmbd_pkg::QUO_W;
  localparam int STEP_W = $clog2(QUO_W);

  // configuration, clamped on write
  logic [BLK_W-1:0] block_x, block_y, block_z;
  logic [REG_W-1:0] region_x, region_y, region_z;
  logic [BLK_W-1:0] blk_in;
  logic [REG_W-1:0] reg_in;

  always_comb begin
    blk_in = cfg_data[BLK_W-1:0];
    if (blk_in == '0) blk_in = BLK_W'(1);
    else if (blk_in > BLK_W'(32)) blk_in = BLK_W'(32);
    reg_in = cfg_data;
    if (reg_in == '0) reg_in = REG_W'(1);
    else if (reg_in > REG_W'(1024)) reg_in = REG_W'(1024);
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_idx <= nmbd_pkg::REG_REGION_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_x <= BLK_W'(1); block_y <= BLK_W'(1); block_z <= BLK_W'(1);
      region_x <= REG_W'(1); region_y <= REG_W'(1); region_z <= REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        nmbd_pkg::REG_BLOCK_X:  block_x  <= blk_in;
        nmbd_pkg::REG_BLOCK_Y:  block_y  <= blk_in;
        nmbd_pkg::REG_BLOCK_Z:  block_z  <= blk_in;
        nmbd_pkg::REG_REGION_X: region_x <= reg_in;
        nmbd_pkg::REG_REGION_Y: region_y <= reg_in;
        nmbd_pkg::REG_REGION_Z: region_z <= reg_in;
        default: ;
      endcase
    end
  end

  // positions kept as cell index + offset, avoiding division
  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [POS_W-1:0] cx, cy, cz;
  logic [BLK_W-1:0] ox, oy, oz;
  // cell indices modulo the store dimensions, as wrapping counters
  logic [AX_W-1:0] mx;
  logic [AY_W-1:0] my;
  logic lx, ly, lz, first;

  assign lx = (ox + BLK_W'(1) == block_x) || ({1'b0, pos_x} + 1'b1 >= region_x);
  assign ly = (oy + BLK_W'(1) == block_y) || ({1'b0, pos_y} + 1'b1 >= region_y);
  assign lz = (oz + BLK_W'(1) == block_z) || ({1'b0, pos_z} + 1'b1 >= region_z);
  assign first = (ox == '0) && (oy == '0) && (oz == '0);

  logic endx, endy, endz;
  assign endx = ({1'b0, pos_x} + 1'b1 >= region_x);
  assign endy = ({1'b0, pos_y} + 1'b1 >= region_y);
  assign endz = ({1'b0, pos_z} + 1'b1 >= region_z);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      cx <= '0; cy <= '0; cz <= '0;
      ox <= '0; oy <= '0; oz <= '0;
      mx <= '0; my <= '0;
    end else if (cmd.accept) begin
      if (!endx) begin
        pos_x <= pos_x + 1'b1;
        if (ox + BLK_W'(1) == block_x) begin
          ox <= '0; cx <= cx + 1'b1;
          mx <= (mx == AX_W'(MAX_CELLS_X - 1)) ? '0 : mx + 1'b1;
        end
        else ox <= ox + 1'b1;
      end else begin
        pos_x <= '0; ox <= '0; cx <= '0; mx <= '0;
        if (!endy) begin
          pos_y <= pos_y + 1'b1;
          if (oy + BLK_W'(1) == block_y) begin
            oy <= '0; cy <= cy + 1'b1;
            my <= (my == AY_W'(MAX_CELLS_Y - 1)) ? '0 : my + 1'b1;
          end
          else oy <= oy + 1'b1;
        end else begin
          pos_y <= '0; oy <= '0; cy <= '0; my <= '0;
          if (!endz) begin
            pos_z <= pos_z + 1'b1;
            if (oz + BLK_W'(1) == block_z) begin oz <= '0; cz <= cz + 1'b1; end
            else oz <= oz + 1'b1;
          end else begin
            pos_z <= '0; oz <= '0; cz <= '0;
          end
        end
      end
    end
  end

  // stores: one read-modify-write per voxel, a read then a write-back
  logic [SUM_W-1:0] sum_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem [DEPTH];
  logic [ADDR_W-1:0] addr, addr_r;
  logic [SUM_W-1:0] sum_rd;
  logic [CNT_W-1:0] cnt_rd;

  assign addr = ADDR_W'(my) * ADDR_W'(MAX_CELLS_X) + ADDR_W'(mx);

  logic signed [SUM_W-1:0] val_r;
  logic nan_r, first_r, emit_r;
  logic [POS_W-1:0] cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_rd  <= sum_mem[addr];
      cnt_rd  <= cnt_mem[addr];
      addr_r  <= addr;
      val_r   <= SUM_W'(signed'(sample[VB-1:0]));
      nan_r   <= is_nan;
      first_r <= first;
      cx_r <= cx; cy_r <= cy; cz_r <= cz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) emit_r <= 1'b0;
    else if (cmd.accept) emit_r <= lx && ly && lz;
  end

  logic signed [SUM_W-1:0] s_new;
  logic [CNT_W-1:0] c_new;
  always_comb begin
    s_new = first_r ? '0 : sum_rd;
    c_new = first_r ? '0 : cnt_rd;
    if (!nan_r) begin
      s_new = s_new + val_r;
      c_new = c_new + 1'b1;
    end
  end

  // write-back happens in the cycle after the read
  logic rmw;
  always_ff @(posedge clk) begin
    if (rst) rmw <= 1'b0;
    else     rmw <= cmd.accept;
  end

  always_ff @(posedge clk) begin
    if (rmw) begin
      sum_mem[addr_r] <= s_new;
      cnt_mem[addr_r] <= c_new;
    end
  end

  // restoring division on magnitudes, one quotient bit per cycle
  logic [QUO_W-1:0] quo;
  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] dvs;
  logic             neg, empty_d;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]   rem_sh;
  logic [POS_W-1:0] ocx, ocy, ocz;

  assign rem_sh = {rem[CNT_W-1:0], quo[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= s_new[SUM_W-1] ? (-s_new) : s_new;
      neg <= s_new[SUM_W-1];
      rem <= '0;
      dvs <= (c_new == '0) ? CNT_W'(1) : c_new;
      empty_d <= (c_new == '0);
      step <= '0;
      ocx <= cx_r; ocy <= cy_r; ocz <= cz_r;
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign sts.div_last = (step == STEP_W'(QUO_W - 1));
  assign sts.emit     = emit_r;
  assign sts.out_full = out_valid && !out_ready;

  logic [QUO_W-1:0] q_signed;
  assign q_signed = neg ? (-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean      <= empty_d ? '0 : q_signed[nmbd_pkg::SAMPLE_W-1:0];
      empty_res <= empty_d;
      cell_x <= ocx; cell_y <= ocy; cell_z <= ocz;
    end
  end

endmodule

[tb/tb_nan_masked_box_downsampler_core.sv]
// Testbench for nan_masked_box_downsampler_core: streams voxel regions under
// several cell/region settings and checks every cell mean against a predictor.
// Depends on nmbd_pkg and the core RTL.
`timescale 1ns / 1ps

class cell_mean_board;
  typedef struct packed {
    logic [31:0] mean;
    logic        empty_res;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [9:0]  cz;
  } cell_res_t;

  int unsigned blk_x, blk_y, blk_z, reg_x, reg_y, reg_z;
  int unsigned px, py, pz;
  longint      sums[4096];
  int unsigned counts[4096];
  cell_res_t   pending[$];
  int          mismatches;

  function void reset_state();
    blk_x = 1; blk_y = 1; blk_z = 1;
    reg_x = 1; reg_y = 1; reg_z = 1;
    px = 0; py = 0; pz = 0;
    pending.delete();
    mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [10:0] data);
    int unsigned b, r;
    b = data[5:0];
    r = data;
    if (b < 1) b = 1;
    if (b > 32) b = 32;
    if (r < 1) r = 1;
    if (r > 1024) r = 1024;
    case (idx)
      nmbd_pkg::REG_BLOCK_X:  blk_x = b;
      nmbd_pkg::REG_BLOCK_Y:  blk_y = b;
      nmbd_pkg::REG_BLOCK_Z:  blk_z = b;
      nmbd_pkg::REG_REGION_X: reg_x = r;
      nmbd_pkg::REG_REGION_Y: reg_y = r;
      nmbd_pkg::REG_REGION_Z: reg_z = r;
      default: return;
    endcase
    px = 0; py = 0; pz = 0;
  endfunction

  // one accepted voxel: accumulate, and queue a result if it closes a cell
  function void note_voxel(logic signed [31:0] sample, logic nan);
    int unsigned cx, cy, cz, addr, c;
    longint s;
    bit first;
    cell_res_t r;
    cx = px / blk_x; cy = py / blk_y; cz = pz / blk_z;
    addr = (cy % 64) * 64 + (cx % 64);
    first = (px % blk_x == 0) && (py % blk_y == 0) && (pz % blk_z == 0);
    s = first ? 0 : sums[addr];
    c = first ? 0 : counts[addr];
    if (!nan) begin
      s += longint'(sample);
      c = (c + 1) & 16'hFFFF;
    end
    sums[addr] = s;
    counts[addr] = c;
    if ((px % blk_x + 1 == blk_x || px + 1 >= reg_x) &&
        (py % blk_y + 1 == blk_y || py + 1 >= reg_y) &&
        (pz % blk_z + 1 == blk_z || pz + 1 >= reg_z)) begin
      r.mean = (c > 0) ? 32'(s / longint'(c)) : '0;
      r.empty_res = (c == 0);
      r.cx = cx[9:0]; r.cy = cy[9:0]; r.cz = cz[9:0];
      pending.insert(pending.size(), r);
    end
    px++;
    if (px >= reg_x) begin
      px = 0; py++;
      if (py >= reg_y) begin
        py = 0; pz++;
        if (pz >= reg_z) pz = 0;
      end
    end
  endfunction

  function void check_cell(logic [63:0] data, logic user);
    cell_res_t want, got;
    got = {data[31:0], user, data[41:32], data[51:42], data[61:52]};
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", data);
      return;
    end
    want = pending.pop_front();
    if (got !== want || data[63:62] !== 2'b00) begin
      mismatches++;
      if (mismatches <= 10)
        $display("cell mismatch: exp mean %h empty %b cell %0d,%0d,%0d; got mean %h empty %b cell %0d,%0d,%0d",
                 want.mean, want.empty_res, want.cx, want.cy, want.cz,
                 got.mean, got.empty_res, got.cx, got.cy, got.cz);
    end
  endfunction
endclass

module tb_nan_masked_box_downsampler_core;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [10:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] sample
  logic        s_axis_tuser = 1'b0; // [0] is_nan
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // mean, cell_x, cell_y, cell_z
  logic        m_axis_tuser;        // [0] empty_res

  cell_mean_board board;
  longint unsigned cycles = 0;
  // each voxel may run the divider and the output load, with long gaps on both
  // sides; ~2000 voxels plus drains, taken several times over
  localparam longint unsigned CYCLE_LIMIT = 1_500_000;

  always #4 clk = ~clk;

  nan_masked_box_downsampler_core u_top (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls; results checked at the accepting edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_cell(m_axis_tdata, m_axis_tuser);
  end

  initial begin : sink
    int unsigned g;
    wait (board != null);
    forever begin
      @(posedge clk);
      g = gap_len();
      if (g == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (g - 1) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_nan_masked_box_downsampler_core: errors");
      $finish;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [10:0] data);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic send_voxel(logic [31:0] sample, logic nan);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1; s_axis_tdata <= sample; s_axis_tuser <= nan;
    do @(posedge clk); while (!s_axis_tready);
    board.note_voxel(sample, nan);
  endtask

  // idle point: every result in, then quiet cycles with the sender held off
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(int bx, by, bz, rx, ry, rz);
    write_cfg(nmbd_pkg::REG_BLOCK_X, 11'(bx));
    write_cfg(nmbd_pkg::REG_BLOCK_Y, 11'(by));
    write_cfg(nmbd_pkg::REG_BLOCK_Z, 11'(bz));
    write_cfg(nmbd_pkg::REG_REGION_X, 11'(rx));
    write_cfg(nmbd_pkg::REG_REGION_Y, 11'(ry));
    write_cfg(nmbd_pkg::REG_REGION_Z, 11'(rz));
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned nvox, bx, by, bz, rx, ry, rz, tot, nanp;
    board = new();
    board.reset_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting (every voxel is its own cell), value extremes
    send_voxel(32'h7FFF_FFFF, 1'b0);
    send_voxel(32'h8000_0000, 1'b0);
    send_voxel(32'hFFFF_FFFF, 1'b0);
    send_voxel(32'h0001_0000, 1'b1); // empty cell
    drain();
    // 2x2x1 cells on a 3x3 region: partial edge cells, all-NaN and extreme sums
    configure(2, 2, 1, 3, 3, 1);
    send_voxel(32'h7FFF_FFFF, 1'b0); send_voxel(32'h7FFF_FFFF, 1'b0);
    send_voxel(32'h1234_5678, 1'b1);
    send_voxel(32'h7FFF_FFFF, 1'b0); send_voxel(32'h0000_0003, 1'b1);
    send_voxel(32'h8000_0000, 1'b0);
    send_voxel(32'hFFFF_FFFD, 1'b0); send_voxel(32'h0000_0002, 1'b0);
    send_voxel(32'h0000_0005, 1'b1);
    drain();
    // zero and oversized values clamp; a write mid-frame restarts it
    configure(0, 63, 0, 0, 2047, 0);
    send_voxel(32'h0000_0007, 1'b0);
    drain();
    configure(2, 1, 2, 2, 1, 2);
    send_voxel(32'hFFFF_FFF9, 1'b0); send_voxel(32'h0000_0002, 1'b0);
    send_voxel(32'h0000_0001, 1'b0); send_voxel(32'h0000_0000, 1'b0);
    drain();

    // random frames; each setting runs one frame, cut at 400 voxels, sender held until idle
    tot = 0;
    while (tot < 1600) begin
      case ($urandom_range(0, 5))
        0: begin bx = 32; by = 1; bz = 1; rx = 70; ry = 1; rz = 1; end
        1: begin bx = 1; by = 1; bz = 1; rx = 1024; ry = 1; rz = 1; end
        2: begin bx = 1; by = 32; bz = 1; rx = 2; ry = 40; rz = 1; end
        3: begin bx = 1; by = 1; bz = 32; rx = 1; ry = 1; rz = 34; end
        default: begin
          bx = $urandom_range(1, 4); by = $urandom_range(1, 4);
          bz = $urandom_range(1, 3);
          rx = $urandom_range(1, 9); ry = $urandom_range(1, 6);
          rz = $urandom_range(1, 4);
        end
      endcase
      configure(bx, by, bz, rx, ry, rz);
      nvox = rx * ry * rz;
      if (nvox > 400) nvox = 400; // partial frame, then reconfigured
      nanp = $urandom_range(0, 3) * 30;
      repeat (nvox) send_voxel(rand_sample(), $urandom_range(0, 99) < nanp);
      tot += nvox;
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb_nan_masked_box_downsampler_core: clean");
    else
      $display("tb_nan_masked_box_downsampler_core: errors");
    $finish;
  end
endmodule
